FILE: hw/rtl/qtea_pkg.sv
`timescale 1ns / 1ps
package qtea_pkg;

    localparam int SW = 36;
    localparam int RW = 30;
    localparam int XW = 38;
    localparam int ZW = 35;
    localparam int SQRT_CELLS = 29;
    localparam int VW = 2 * SQRT_CELLS;
    localparam int QW = SQRT_CELLS;
    localparam int REMW = QW + 4;
    localparam int TABLE_LEN = 24;

    localparam logic signed [ZW-1:0] PI_Q30 = 35'sd3373259426;
    localparam logic signed [ZW-1:0] HALF_PI_Q30 = 35'sd1686629713;
    localparam logic signed [RW-1:0] ONE_Q28 = 30'sd268435456;

    typedef logic signed [ZW-1:0] ang_t;
    typedef logic signed [ZW:0] angr_t;
    typedef logic signed [XW-1:0] coord_t;

    typedef struct packed {
        logic signed [SW-1:0] sinp;
        logic signed [SW-1:0] cosp;
        logic signed [SW-1:0] siny;
        logic signed [SW-1:0] cosy;
        logic signed [RW-1:0] sinr;
        logic                 clamped;
    } trig_t;

    typedef struct packed {
        trig_t             t;
        logic [VW-1:0]     v;
        logic [REMW-1:0]   rem;
        logic [QW-1:0]     q;
    } sq_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        ang_t   z;
        logic   zero;
    } vec_t;

    typedef struct packed {
        vec_t pv;
        vec_t yv;
        vec_t rv;
        logic clamped;
    } rot_t;

    function automatic ang_t atan_q30(input int k);
        ang_t a;
        case (k)
            0:  a = 35'sh3243F6A8;
            1:  a = 35'sh1DAC6705;
            2:  a = 35'sh0FADBAFC;
            3:  a = 35'sh07F56EA6;
            4:  a = 35'sh03FEAB76;
            5:  a = 35'sh01FFD55B;
            6:  a = 35'sh00FFFAAA;
            7:  a = 35'sh007FFF55;
            8:  a = 35'sh003FFFEA;
            9:  a = 35'sh001FFFFD;
            10: a = 35'sh000FFFFF;
            11: a = 35'sh0007FFFF;
            12: a = 35'sh0003FFFF;
            13: a = 35'sh0001FFFF;
            14: a = 35'sh0000FFFF;
            15: a = 35'sh00007FFF;
            16: a = 35'sh00003FFF;
            17: a = 35'sh00001FFF;
            18: a = 35'sh00000FFF;
            19: a = 35'sh000007FF;
            20: a = 35'sh000003FF;
            21: a = 35'sh000001FF;
            22: a = 35'sh000000FF;
            23: a = 35'sh0000007F;
            default: a = '0;
        endcase
        return a;
    endfunction

    // turn a left-half-plane vector into the right half plane
    function automatic vec_t prerot(input coord_t y, input coord_t x);
        vec_t v;
        v.zero = (x == '0) && (y == '0);
        if (x < 0) begin
            if (y >= 0) begin
                v.x = y;
                v.y = -x;
                v.z = HALF_PI_Q30;
            end
            else begin
                v.x = -y;
                v.y = x;
                v.z = -HALF_PI_Q30;
            end
        end
        else begin
            v.x = x;
            v.y = y;
            v.z = '0;
        end
        return v;
    endfunction

endpackage

FILE: hw/rtl/qtea_front.sv
`timescale 1ns / 1ps
module qtea_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic signed [15:0]     qi,
    input  logic signed [15:0]     qj,
    input  logic signed [15:0]     qk,
    input  logic signed [15:0]     qr,
    output logic                   out_valid,
    input  logic                   out_ready,
    output qtea_pkg::sq_t          out_data
);

    logic signed [31:0] rj_reg, ik_reg, ii_reg, jj_reg, rk_reg, ij_reg, kk_reg, ri_reg, jk_reg;
    qtea_pkg::trig_t    t_reg, t_next;
    qtea_pkg::sq_t      s_reg, s_next;
    logic               v1_reg, v2_reg, v3_reg;
    logic               rdy1, rdy2, rdy3;
    logic signed [qtea_pkg::SW-1:0] sinr_raw;
    logic signed [2*qtea_pkg::RW-1:0] sq;

    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;
    assign out_valid = v3_reg;
    assign out_data  = s_reg;

    always_comb
    begin
        t_next.sinp = (qtea_pkg::SW'(rj_reg) - qtea_pkg::SW'(ik_reg)) <<< 1;
        t_next.cosp = qtea_pkg::SW'(qtea_pkg::ONE_Q28)
                    - ((qtea_pkg::SW'(ii_reg) + qtea_pkg::SW'(jj_reg)) <<< 1);
        t_next.siny = (qtea_pkg::SW'(rk_reg) + qtea_pkg::SW'(ij_reg)) <<< 1;
        t_next.cosy = qtea_pkg::SW'(qtea_pkg::ONE_Q28)
                    - ((qtea_pkg::SW'(jj_reg) + qtea_pkg::SW'(kk_reg)) <<< 1);
        sinr_raw    = (qtea_pkg::SW'(ri_reg) + qtea_pkg::SW'(jk_reg)) <<< 1;
        t_next.clamped = 1'b0;
        t_next.sinr = qtea_pkg::RW'(sinr_raw);
        if (sinr_raw > qtea_pkg::SW'(qtea_pkg::ONE_Q28))
        begin
            t_next.sinr    = qtea_pkg::ONE_Q28;
            t_next.clamped = 1'b1;
        end
        else if (sinr_raw < -qtea_pkg::SW'(qtea_pkg::ONE_Q28))
        begin
            t_next.sinr    = -qtea_pkg::ONE_Q28;
            t_next.clamped = 1'b1;
        end
    end

    always_comb
    begin
        sq = t_reg.sinr * t_reg.sinr;
        s_next.t   = t_reg;
        s_next.v   = qtea_pkg::VW'(58'd1 << 56) - qtea_pkg::VW'(sq);
        s_next.rem = '0;
        s_next.q   = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            rj_reg <= qr * qj;
            ik_reg <= qi * qk;
            ii_reg <= qi * qi;
            jj_reg <= qj * qj;
            rk_reg <= qr * qk;
            ij_reg <= qi * qj;
            kk_reg <= qk * qk;
            ri_reg <= qr * qi;
            jk_reg <= qj * qk;
        end
        if (rdy2 && v1_reg) t_reg <= t_next;
        if (rdy3 && v2_reg) s_reg <= s_next;
    end

endmodule

FILE: hw/rtl/qtea_sqrt_cell.sv
`timescale 1ns / 1ps
module qtea_sqrt_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  qtea_pkg::sq_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output qtea_pkg::sq_t  out_data
);

    qtea_pkg::sq_t d_reg, d_next;
    logic          v_reg;
    logic [qtea_pkg::REMW-1:0] r2, trial;

    assign in_ready  = !v_reg || out_ready;
    assign out_valid = v_reg;
    assign out_data  = d_reg;

    // one root bit: bring down two radicand bits, try (2q << 1) | 1
    always_comb
    begin
        r2    = {in_data.rem[qtea_pkg::REMW-3:0], in_data.v[qtea_pkg::VW-1 -: 2]};
        trial = qtea_pkg::REMW'({in_data.q, 2'b01});
        d_next   = in_data;
        d_next.v = in_data.v << 2;
        if (r2 >= trial)
        begin
            d_next.rem = r2 - trial;
            d_next.q   = {in_data.q[qtea_pkg::QW-2:0], 1'b1};
        end
        else
        begin
            d_next.rem = r2;
            d_next.q   = {in_data.q[qtea_pkg::QW-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (in_ready)
            v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid) d_reg <= d_next;
    end

endmodule

FILE: hw/rtl/qtea_prerot.sv
`timescale 1ns / 1ps
module qtea_prerot (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  qtea_pkg::sq_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output qtea_pkg::rot_t out_data
);

    qtea_pkg::rot_t d_reg, d_next;
    logic           v_reg;

    assign in_ready  = !v_reg || out_ready;
    assign out_valid = v_reg;
    assign out_data  = d_reg;

    always_comb
    begin
        d_next.pv = qtea_pkg::prerot(qtea_pkg::XW'(in_data.t.sinp),
                                     qtea_pkg::XW'(in_data.t.cosp));
        d_next.yv = qtea_pkg::prerot(qtea_pkg::XW'(in_data.t.siny),
                                     qtea_pkg::XW'(in_data.t.cosy));
        d_next.rv = qtea_pkg::prerot(qtea_pkg::XW'(in_data.t.sinr),
                                     qtea_pkg::coord_t'({1'b0, in_data.q}));
        d_next.clamped = in_data.t.clamped;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (in_ready)
            v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid) d_reg <= d_next;
    end

endmodule

FILE: hw/rtl/qtea_rot_cell.sv
`timescale 1ns / 1ps
module qtea_rot_cell #(
    parameter int K = 0
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  qtea_pkg::rot_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output qtea_pkg::rot_t out_data
);

    localparam qtea_pkg::ang_t ATAN_K = qtea_pkg::atan_q30(K);

    qtea_pkg::rot_t d_reg, d_next;
    logic           v_reg;

    function automatic qtea_pkg::vec_t step(input qtea_pkg::vec_t a);
        qtea_pkg::vec_t b;
        qtea_pkg::coord_t xs, ys;
        xs = a.x >>> K;
        ys = a.y >>> K;
        b  = a;
        if (a.y > 0)
        begin
            b.x = a.x + ys;
            b.y = a.y - xs;
            b.z = a.z + ATAN_K;
        end
        else
        begin
            b.x = a.x - ys;
            b.y = a.y + xs;
            b.z = a.z - ATAN_K;
        end
        return b;
    endfunction

    assign in_ready  = !v_reg || out_ready;
    assign out_valid = v_reg;
    assign out_data  = d_reg;

    always_comb
    begin
        d_next.pv      = step(in_data.pv);
        d_next.yv      = step(in_data.yv);
        d_next.rv      = step(in_data.rv);
        d_next.clamped = in_data.clamped;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (in_ready)
            v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid) d_reg <= d_next;
    end

endmodule

FILE: hw/rtl/qtea_finish.sv
`timescale 1ns / 1ps
module qtea_finish #(
    parameter int ANGLE_FRAC_BITS = 13
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  qtea_pkg::rot_t     in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] pitch,
    output logic signed [14:0] roll,
    output logic signed [15:0] yaw,
    output logic               clamped
);

    localparam int RSH = 30 - ANGLE_FRAC_BITS;
    localparam qtea_pkg::angr_t RND = qtea_pkg::angr_t'(64'd1 << (RSH - 1));

    logic               v_reg;
    logic signed [15:0] pitch_reg, yaw_reg;
    logic signed [14:0] roll_reg;
    logic               clamped_reg;
    qtea_pkg::ang_t     zp, zy, zr;
    qtea_pkg::angr_t    rp, ry, rr;

    function automatic qtea_pkg::ang_t sat(input qtea_pkg::vec_t v, input qtea_pkg::ang_t lim);
        qtea_pkg::ang_t z;
        z = v.zero ? '0 : v.z;
        if (z > lim) z = lim;
        if (z < -lim) z = -lim;
        return z;
    endfunction

    assign in_ready  = !v_reg || out_ready;
    assign out_valid = v_reg;
    assign pitch     = pitch_reg;
    assign roll      = roll_reg;
    assign yaw       = yaw_reg;
    assign clamped   = clamped_reg;

    always_comb
    begin
        zp = sat(in_data.pv, qtea_pkg::PI_Q30);
        zy = sat(in_data.yv, qtea_pkg::PI_Q30);
        zr = sat(in_data.rv, qtea_pkg::HALF_PI_Q30);
        rp = (qtea_pkg::angr_t'(zp) + RND) >>> RSH;
        ry = (qtea_pkg::angr_t'(zy) + RND) >>> RSH;
        rr = (qtea_pkg::angr_t'(zr) + RND) >>> RSH;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (in_ready)
            v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            pitch_reg   <= rp[15:0];
            roll_reg    <= rr[14:0];
            yaw_reg     <= ry[15:0];
            clamped_reg <= in_data.clamped;
        end
    end

endmodule

FILE: hw/rtl/quaternion_to_euler_angles_top.sv
// Pipeline: an accepted quaternion beat passes through these registered stages to its angle beat
// (3 product/sum cells, 29 root cells, 1 quadrant cell, CORDIC_STEPS rotation cells, 1 output).
// Throughput: one beat per cycle while euler_ready is high; every cell is a one-deep stage with its own valid bit.
// Reset: rst_n clears all valid bits asynchronously; the pipe is empty and ready after reset.
`timescale 1ns / 1ps
module quaternion_to_euler_angles_top #(
    parameter int CORDIC_STEPS    = 14,
    parameter int ANGLE_FRAC_BITS = 13
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               quat_valid,
    output logic               quat_ready,
    input  logic signed [15:0] quat_i,
    input  logic signed [15:0] quat_j,
    input  logic signed [15:0] quat_k,
    input  logic signed [15:0] quat_real,
    output logic               euler_valid,
    input  logic               euler_ready,
    output logic signed [15:0] pitch_angle,
    output logic signed [14:0] roll_angle,
    output logic signed [15:0] yaw_angle,
    output logic               roll_clamped
);

    qtea_pkg::sq_t  sq_d [0:qtea_pkg::SQRT_CELLS];
    logic           sq_v [0:qtea_pkg::SQRT_CELLS];
    logic           sq_r [0:qtea_pkg::SQRT_CELLS];
    qtea_pkg::rot_t rot_d [0:CORDIC_STEPS];
    logic           rot_v [0:CORDIC_STEPS];
    logic           rot_r [0:CORDIC_STEPS];

    qtea_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (quat_valid),
        .in_ready  (quat_ready),
        .qi        (quat_i),
        .qj        (quat_j),
        .qk        (quat_k),
        .qr        (quat_real),
        .out_valid (sq_v[0]),
        .out_ready (sq_r[0]),
        .out_data  (sq_d[0])
    );

    for (genvar n = 0; n < qtea_pkg::SQRT_CELLS; n++)
    begin : g_sqrt
        qtea_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (sq_v[n]),
            .in_ready  (sq_r[n]),
            .in_data   (sq_d[n]),
            .out_valid (sq_v[n+1]),
            .out_ready (sq_r[n+1]),
            .out_data  (sq_d[n+1])
        );
    end

    qtea_prerot u_prerot (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_v[qtea_pkg::SQRT_CELLS]),
        .in_ready  (sq_r[qtea_pkg::SQRT_CELLS]),
        .in_data   (sq_d[qtea_pkg::SQRT_CELLS]),
        .out_valid (rot_v[0]),
        .out_ready (rot_r[0]),
        .out_data  (rot_d[0])
    );

    for (genvar n = 0; n < CORDIC_STEPS; n++)
    begin : g_rot
        qtea_rot_cell #(
            .K (n)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (rot_v[n]),
            .in_ready  (rot_r[n]),
            .in_data   (rot_d[n]),
            .out_valid (rot_v[n+1]),
            .out_ready (rot_r[n+1]),
            .out_data  (rot_d[n+1])
        );
    end

    qtea_finish #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_finish (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rot_v[CORDIC_STEPS]),
        .in_ready  (rot_r[CORDIC_STEPS]),
        .in_data   (rot_d[CORDIC_STEPS]),
        .out_valid (euler_valid),
        .out_ready (euler_ready),
        .pitch     (pitch_angle),
        .roll      (roll_angle),
        .yaw       (yaw_angle),
        .clamped   (roll_clamped)
    );

endmodule

FILE: hw/rtl/qtea_checker.sv
`timescale 1ns / 1ps
module qtea_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               quat_ready,
    input logic               euler_valid,
    input logic               euler_ready,
    input logic signed [15:0] pitch_angle,
    input logic signed [14:0] roll_angle,
    input logic signed [15:0] yaw_angle,
    input logic               roll_clamped
);

    a_reset_empty: assert property (@(posedge clk) !rst_n |=> !euler_valid)
        else $error("result beat shown during reset");

    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (!euler_valid || euler_ready) |-> quat_ready)
        else $error("input stalled while output drains");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        euler_valid && !euler_ready |=> euler_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        euler_valid && !euler_ready |=> $stable(pitch_angle) && $stable(roll_angle)
        && $stable(yaw_angle) && $stable(roll_clamped))
        else $error("result beat changed while stalled");

endmodule

bind quaternion_to_euler_angles_top qtea_checker u_qtea_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .quat_ready   (quat_ready),
    .euler_valid  (euler_valid),
    .euler_ready  (euler_ready),
    .pitch_angle  (pitch_angle),
    .roll_angle   (roll_angle),
    .yaw_angle    (yaw_angle),
    .roll_clamped (roll_clamped)
);

FILE: tb/sv/quaternion_to_euler_angles_top_tb.sv
`timescale 1ns / 1ps
module quaternion_to_euler_angles_top_tb;

    localparam int STEPS = 14;
    localparam int FRAC = 13;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES = STEPS + 60;
    localparam longint ONE = 64'sd1 << 28;
    localparam longint PI30 = 64'sd3373259426;
    localparam longint HPI30 = 64'sd1686629713;

    typedef struct packed {
        logic signed [15:0] pitch;
        logic signed [14:0] roll;
        logic signed [15:0] yaw;
        logic               clamped;
    } euler_t;

    logic               clk;
    logic               rst_n;
    logic               quat_valid;
    logic               quat_ready;
    logic signed [15:0] quat_i;
    logic signed [15:0] quat_j;
    logic signed [15:0] quat_k;
    logic signed [15:0] quat_real;
    logic               euler_valid;
    logic               euler_ready;
    logic signed [15:0] pitch_angle;
    logic signed [14:0] roll_angle;
    logic signed [15:0] yaw_angle;
    logic               roll_clamped;

    euler_t angles_due[$];
    int     errors;
    int     idle_cycles;

    quaternion_to_euler_angles_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .quat_valid   (quat_valid),
        .quat_ready   (quat_ready),
        .quat_i       (quat_i),
        .quat_j       (quat_j),
        .quat_k       (quat_k),
        .quat_real    (quat_real),
        .euler_valid  (euler_valid),
        .euler_ready  (euler_ready),
        .pitch_angle  (pitch_angle),
        .roll_angle   (roll_angle),
        .yaw_angle    (yaw_angle),
        .roll_clamped (roll_clamped)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic longint atan_step(input int n);
        longint tab[24] = '{
            64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
            64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
            64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
            64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
            64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};
        return tab[n];
    endfunction

    function automatic longint vector_angle(input longint sy, input longint sx);
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        x = sx;
        y = sy;
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        if (x < 0)
        begin
            if (y >= 0)
            begin
                x = sy;
                y = -sx;
                z = HPI30;
            end
            else
            begin
                x = -sy;
                y = sx;
                z = -HPI30;
            end
        end
        for (int n = 0; n < STEPS && n < 24; n++)
        begin
            xs = x >>> n;
            ys = y >>> n;
            if (y > 0)
            begin
                x += ys;
                y -= xs;
                z += atan_step(n);
            end
            else
            begin
                x -= ys;
                y += xs;
                z -= atan_step(n);
            end
        end
        if (z > PI30) z = PI30;
        if (z < -PI30) z = -PI30;
        return z;
    endfunction

    function automatic longint floor_root(input longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic longint round_angle(input longint z);
        return (z + (64'sd1 << (30 - FRAC - 1))) >>> (30 - FRAC);
    endfunction

    function automatic euler_t predict_angles(input logic signed [15:0] qi,
                                              input logic signed [15:0] qj,
                                              input logic signed [15:0] qk,
                                              input logic signed [15:0] qr);
        longint i;
        longint j;
        longint k;
        longint r;
        longint sinr;
        longint roll;
        longint p;
        longint yw;
        euler_t e;
        i = qi;
        j = qj;
        k = qk;
        r = qr;
        e.clamped = 1'b0;
        sinr = 2 * (r * i + j * k);
        if (sinr > ONE)
        begin
            sinr = ONE;
            e.clamped = 1'b1;
        end
        if (sinr < -ONE)
        begin
            sinr = -ONE;
            e.clamped = 1'b1;
        end
        p = vector_angle(2 * (r * j - i * k), ONE - 2 * (i * i + j * j));
        yw = vector_angle(2 * (r * k + i * j), ONE - 2 * (j * j + k * k));
        roll = vector_angle(sinr, floor_root((64'd1 << 56) - longint'(sinr * sinr)));
        if (roll > HPI30) roll = HPI30;
        if (roll < -HPI30) roll = -HPI30;
        p = round_angle(p);
        roll = round_angle(roll);
        yw = round_angle(yw);
        e.pitch = p[15:0];
        e.roll = roll[14:0];
        e.yaw = yw[15:0];
        return e;
    endfunction

    task automatic send_quat(input logic signed [15:0] qi, input logic signed [15:0] qj,
                             input logic signed [15:0] qk, input logic signed [15:0] qr);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            quat_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        quat_valid <= 1'b1;
        quat_i <= qi;
        quat_j <= qj;
        quat_k <= qk;
        quat_real <= qr;
        do @(posedge clk); while (!quat_ready);
        angles_due.push_back(predict_angles(qi, qj, qk, qr));
    endtask

    function automatic logic signed [15:0] rand_comp();
        return 16'(int'($urandom_range(0, 32768)) - 16384);
    endfunction

    task automatic send_unit_quat();
        real a;
        real b;
        real c;
        real d;
        real n;
        a = real'($urandom_range(0, 20000)) - 10000.0;
        b = real'($urandom_range(0, 20000)) - 10000.0;
        c = real'($urandom_range(0, 20000)) - 10000.0;
        d = real'($urandom_range(0, 20000)) - 10000.0;
        n = $sqrt(a * a + b * b + c * c + d * d);
        if (n < 1.0)
        begin
            a = 1.0;
            n = 1.0;
        end
        send_quat(16'($rtoi(a / n * 16384.0)), 16'($rtoi(b / n * 16384.0)),
                  16'($rtoi(c / n * 16384.0)), 16'($rtoi(d / n * 16384.0)));
    endtask

    task automatic test_extremes();
        send_quat(0, 0, 0, 16384);
        send_quat(0, 0, 0, 0);
        send_quat(16384, 0, 0, 0);
        send_quat(0, 16384, 0, 0);
        send_quat(0, 0, 16384, 0);
        send_quat(-16384, 0, 0, 0);
        send_quat(0, 0, 0, -16384);
        send_quat(16384, 16384, 16384, 16384);
        send_quat(-16384, -16384, -16384, -16384);
        send_quat(11585, 0, 0, 11585);
        send_quat(-11585, 0, 0, 11585);
        send_quat(0, 11585, 0, 11585);
        send_quat(0, 0, 11585, -11585);
        send_quat(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_quat(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        send_quat(16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
        send_quat(16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA);
        send_quat(16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555);
        send_quat(8192, 8192, 8192, 8192);
        send_quat(-8192, 8192, -8192, 8192);
    endtask

    task automatic test_unit_quats();
        repeat (1100) send_unit_quat();
    endtask

    task automatic test_random_fields();
        repeat (300) send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
        repeat (100) send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    initial
    begin
        int stall;
        forever
        begin
            stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
            if (stall > 0)
            begin
                euler_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            euler_ready <= 1'b1;
            do @(posedge clk); while (!euler_valid);
        end
    end

    always @(posedge clk)
    begin
        euler_t e;
        if (rst_n && euler_valid && euler_ready)
        begin
            if (angles_due.size() == 0)
            begin
                $error("unexpected beat: pitch %0d roll %0d yaw %0d",
                       pitch_angle, roll_angle, yaw_angle);
                errors++;
            end
            else
            begin
                e = angles_due.pop_front();
                if (pitch_angle !== e.pitch)
                begin
                    $error("pitch_angle expected %0d actual %0d", e.pitch, pitch_angle);
                    errors++;
                end
                if (roll_angle !== e.roll)
                begin
                    $error("roll_angle expected %0d actual %0d", e.roll, roll_angle);
                    errors++;
                end
                if (yaw_angle !== e.yaw)
                begin
                    $error("yaw_angle expected %0d actual %0d", e.yaw, yaw_angle);
                    errors++;
                end
                if (roll_clamped !== e.clamped)
                begin
                    $error("roll_clamped expected %0d actual %0d", e.clamped, roll_clamped);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((quat_valid && quat_ready) || (euler_valid && euler_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        quat_valid = 1'b0;
        quat_i = '0;
        quat_j = '0;
        quat_k = '0;
        quat_real = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_unit_quats();
        test_random_fields();
        quat_valid <= 1'b0;
        while (angles_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
